// File: rtl/position_residue_profile_defines.svh
// ----------------------------------------------------------------------------
// position residue profile assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef POSITION_RESIDUE_PROFILE_DEFINES_SVH
`define POSITION_RESIDUE_PROFILE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define PRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prp port check failed");

// next-cycle implication, off while reset is asserted
`define PRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prp port check failed");

// next-cycle implication that also holds across reset
`define PRP_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("prp port check failed");

`endif

// File: rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// shared widths, defaults and codes of the position residue profile
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

    // parameter defaults
    localparam int POSITIONS_DEF  = 1024;
    localparam int ALPHABET_DEF   = 256;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int POS_FW   = 10;
    localparam int RES_FW   = 8;
    localparam int RANK_FW  = 8;
    localparam int CNT_FW   = 16;
    localparam int PCT_FW   = 10;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    // percentage scale in tenths of a percent
    localparam int PCT_SCALE = 1000;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage

`default_nettype wire

// File: rtl/position_residue_profile.sv
// ----------------------------------------------------------------------------
// position_residue_profile
// per-position residue frequency profile with ranked queries
// ----------------------------------------------------------------------------
// A count transfer adds one observation to a (position, residue) cell and to
// the position total, both saturating; it steps through accept, read and write
// back and gives no result. A query transfer walks the alphabet of its
// position: each candidate code is read and skipped if its count is zero, and
// for each seen candidate the rank is found by a scan of the whole column
// through the single cell memory read port and the shared subtractor; a hit
// then goes through the restoring divider, which uses the same subtractor, and
// an output step. After reset a clearing pass writes zero to every cell and
// total, one cell a cycle, over POSITIONS*2^ceil(log2(ALPHABET)) cells (262144
// at the defaults); s_tready stays low meanwhile. A position out of range, or
// a residue out of range on a count, is accepted and dropped, and a query
// with no residue at the rank gives no result.
// ----------------------------------------------------------------------------
`default_nettype none

module position_residue_profile #(
    parameter int POSITIONS  = prp_pkg::POSITIONS_DEF,
    parameter int ALPHABET   = prp_pkg::ALPHABET_DEF,
    parameter int COUNT_BITS = prp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // position [9:0], residue [17:10], rank [25:18], zero [31:26]
    input  wire logic [prp_pkg::S_DATA_W-1:0]  s_tdata,
    // op [0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // ranked_residue [7:0], residue_count [23:8], column_total [39:24],
    // percent_tenths [49:40], zero [55:50]
    output logic [prp_pkg::M_DATA_W-1:0]       m_tdata,
    // found [0]
    output logic                               m_tuser
);

    localparam int PW      = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int AW      = $clog2(ALPHABET);
    localparam int CW      = COUNT_BITS;
    localparam int CELL_AW = PW + AW;
    localparam int CELL_DEPTH = POSITIONS * (2 ** AW);
    localparam int PF      = prp_pkg::PCT_FW;
    localparam int RANK_W  = prp_pkg::RANK_FW;

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CNT_RD  = 9'b000000100,
        ST_CNT_WR  = 9'b000001000,
        ST_Q_CAND  = 9'b000010000,
        ST_Q_CWAIT = 9'b000100000,
        ST_Q_SCAN  = 9'b001000000,
        ST_Q_DIV   = 9'b010000000,
        ST_Q_OUT   = 9'b100000000
    } state_t;

    localparam logic [AW-1:0]      LAST_CODE = AW'(ALPHABET - 1);
    localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELL_DEPTH - 1);
    localparam logic [CW-1:0]      COUNT_MAX = {CW{1'b1}};
    localparam logic [3:0]         DIV_LAST  = 4'(PF - 1);

    // memories
    logic [CW-1:0] cell_mem [0:CELL_DEPTH-1];
    logic [CW-1:0] tot_mem  [0:POSITIONS-1];

    state_t               state_reg, state_next;
    logic [CELL_AW-1:0]   clr_reg, clr_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        res_reg, res_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic [AW-1:0]        c_reg, c_next;
    logic [AW-1:0]        d_issue_reg, d_issue_next;
    logic [AW-1:0]        d_q_reg, d_q_next;
    logic                 scan_vld_reg, scan_vld_next;
    logic [AW-1:0]        r_reg, r_next;
    logic [CW-1:0]        cc_reg, cc_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [PF-1:0]        low_reg, low_next;
    logic [PF-1:0]        q_reg, q_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [prp_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    // memory ports
    logic [CELL_AW-1:0]   cell_rd_addr;
    logic [CW-1:0]        cell_q;
    logic [CW-1:0]        tot_q;
    logic                 cell_we;
    logic [CELL_AW-1:0]   cell_wr_addr;
    logic [CW-1:0]        cell_wr_data;
    logic                 tot_we;
    logic [PW-1:0]        tot_wr_addr;
    logic [CW-1:0]        tot_wr_data;

    // input fields
    logic [prp_pkg::POS_FW-1:0]  in_pos;
    logic [prp_pkg::RES_FW-1:0]  in_res;
    logic [RANK_W-1:0]           in_rank;
    logic [31:0]                 in_pos_ext;
    logic [31:0]                 in_res_ext;
    logic                        in_pos_ok;
    logic                        in_res_ok;

    assign in_pos     = s_tdata[9:0];
    assign in_res     = s_tdata[17:10];
    assign in_rank    = s_tdata[25:18];
    assign in_pos_ext = 32'(in_pos);
    assign in_res_ext = 32'(in_res);
    assign in_pos_ok  = (in_pos_ext < 32'(POSITIONS));
    assign in_res_ok  = (in_res_ext < 32'(ALPHABET));

    // shared subtractor: count compare during the scan, trial subtract in the divider
    logic [CW:0]   sub_a, sub_b;
    logic [CW+1:0] sub_diff;
    logic          sub_borrow;
    logic          sub_zero;

    always_comb begin
        if (state_reg == ST_Q_DIV) begin
            sub_a = {rem_reg, low_reg[PF-1]};
            sub_b = {1'b0, tot_q};
        end else begin
            sub_a = {1'b0, cell_q};
            sub_b = {1'b0, cc_reg};
        end
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[CW+1];
    assign sub_zero   = (sub_diff == '0);

    // scan hit: the scanned code ranks ahead of the candidate
    logic          scan_hit;
    logic [AW-1:0] r_final;

    assign scan_hit = scan_vld_reg &&
                      ((!sub_borrow && !sub_zero) || (sub_zero && (d_q_reg < c_reg)));
    assign r_final  = r_reg + AW'(scan_hit);

    logic [CW+PF-1:0] prod;
    assign prod = (CW+PF)'(cc_reg) * (CW+PF)'(prp_pkg::PCT_SCALE);

    logic [31:0] cc_ext;
    logic [31:0] tot_ext;
    assign cc_ext  = 32'(cc_reg);
    assign tot_ext = 32'(tot_q);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        rank_next      = rank_reg;
        c_next         = c_reg;
        d_issue_next   = d_issue_reg;
        d_q_next       = d_q_reg;
        scan_vld_next  = scan_vld_reg;
        r_next         = r_reg;
        cc_next        = cc_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        q_next         = q_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        cell_rd_addr   = {pos_reg, c_reg};
        cell_we        = 1'b0;
        cell_wr_addr   = {pos_reg, res_reg};
        cell_wr_data   = (cell_q == COUNT_MAX) ? cell_q : cell_q + CW'(1);
        tot_we         = 1'b0;
        tot_wr_addr    = pos_reg;
        tot_wr_data    = (tot_q == COUNT_MAX) ? tot_q : tot_q + CW'(1);

        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                cell_we      = 1'b1;
                cell_wr_addr = clr_reg;
                cell_wr_data = '0;
                tot_we       = (clr_reg[AW-1:0] == '0);
                tot_wr_addr  = clr_reg[CELL_AW-1:AW];
                tot_wr_data  = '0;
                clr_next     = clr_reg + CELL_AW'(1);
                if (clr_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                pos_next  = in_pos_ext[PW-1:0];
                res_next  = in_res_ext[AW-1:0];
                rank_next = in_rank;
                c_next    = '0;
                if (s_tvalid && in_pos_ok) begin
                    if (s_tuser == prp_pkg::OP_QUERY) begin
                        state_next = ST_Q_CAND;
                    end else if (in_res_ok) begin
                        state_next = ST_CNT_RD;
                    end
                end
            end
            ST_CNT_RD: begin
                cell_rd_addr = {pos_reg, res_reg};
                state_next   = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                cell_we    = 1'b1;
                tot_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_CAND: begin
                cell_rd_addr = {pos_reg, c_reg};
                state_next   = ST_Q_CWAIT;
            end
            ST_Q_CWAIT: begin
                if (cell_q == '0) begin
                    if (c_reg == LAST_CODE) begin
                        state_next = ST_IDLE;
                    end else begin
                        c_next     = c_reg + AW'(1);
                        state_next = ST_Q_CAND;
                    end
                end else begin
                    cc_next       = cell_q;
                    d_issue_next  = '0;
                    scan_vld_next = 1'b0;
                    r_next        = '0;
                    state_next    = ST_Q_SCAN;
                end
            end
            ST_Q_SCAN: begin
                // one read issued per cycle, compared in the next cycle
                cell_rd_addr  = {pos_reg, d_issue_reg};
                d_q_next      = d_issue_reg;
                scan_vld_next = 1'b1;
                if (d_issue_reg != LAST_CODE) begin
                    d_issue_next = d_issue_reg + AW'(1);
                end
                r_next = r_final;
                if (scan_vld_reg && (d_q_reg == LAST_CODE)) begin
                    scan_vld_next = 1'b0;
                    if (9'(r_final) == {1'b0, rank_reg}) begin
                        rem_next     = prod[CW+PF-1:PF];
                        low_next     = prod[PF-1:0];
                        q_next       = '0;
                        div_cnt_next = '0;
                        state_next   = ST_Q_DIV;
                    end else if (c_reg == LAST_CODE) begin
                        state_next = ST_IDLE;
                    end else begin
                        c_next     = c_reg + AW'(1);
                        state_next = ST_Q_CAND;
                    end
                end
            end
            ST_Q_DIV: begin
                // restoring division, one quotient bit a cycle
                rem_next     = sub_borrow ? sub_a[CW-1:0] : sub_diff[CW-1:0];
                low_next     = {low_reg[PF-2:0], 1'b0};
                q_next       = {q_reg[PF-2:0], !sub_borrow};
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, q_reg, tot_ext[15:0], cc_ext[15:0], 8'(c_reg)};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        res_reg      <= res_next;
        rank_reg     <= rank_next;
        c_reg        <= c_next;
        d_issue_reg  <= d_issue_next;
        d_q_reg      <= d_q_next;
        scan_vld_reg <= scan_vld_next;
        r_reg        <= r_next;
        cc_reg       <= cc_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        q_reg        <= q_next;
        div_cnt_reg  <= div_cnt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_wr_addr] <= cell_wr_data;
        end
        cell_q <= cell_mem[cell_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (tot_we) begin
            tot_mem[tot_wr_addr] <= tot_wr_data;
        end
        tot_q <= tot_mem[pos_reg];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = 1'b1;

endmodule

`default_nettype wire

// File: rtl/prp_checker.sv
// ----------------------------------------------------------------------------
// prp_checker
// port-level checks of the position residue profile, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "position_residue_profile_defines.svh"

module prp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [prp_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                          m_tuser
);

    logic [prp_pkg::PCT_FW-1:0] pct;
    logic                       s_xfer;

    assign pct    = m_tdata[49:40];
    assign s_xfer = s_tvalid && s_tready;

    // a stalled result holds
    `PRP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // every result is a hit with a share of at most the whole total
    `PRP_ASSERT_SAME(a_out_range, aclk, aresetn, m_tvalid, m_tuser && (pct <= 10'd1000))

    // a query passes through its scan and division first, so no result shows right after a transfer
    `PRP_ASSERT_NEXT(a_no_instant, aclk, aresetn, s_xfer, !$rose(m_tvalid))

    // the clearing pass holds off input after reset
    `PRP_ASSERT_NEXT_ANY(a_clear_hold, aclk, !aresetn, !s_tready)

endmodule

bind position_residue_profile prp_checker u_prp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// position residue profile testbench
// Drives count and query transfers into the profile block and keeps its own
// copy of every cell count and column total. Each accepted query is ranked
// against that copy, and each returned result is compared field by field in
// order. The run covers directed edge cases and random traffic under three
// backpressure mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int POSITIONS   = prp_pkg::POSITIONS_DEF;
    localparam int ALPHABET    = prp_pkg::ALPHABET_DEF;
    localparam int POS_W       = prp_pkg::POS_FW;
    localparam int RES_W       = prp_pkg::RES_FW;
    localparam int RANK_W      = prp_pkg::RANK_FW;
    localparam int CNT_W       = prp_pkg::CNT_FW;
    localparam int PCT_W       = prp_pkg::PCT_FW;
    localparam int S_DW        = prp_pkg::S_DATA_W;
    localparam int M_DW        = prp_pkg::M_DATA_W;
    localparam int HOT_N       = 16;
    localparam int POOL_N      = 6;
    localparam int PHASE_ITEMS = 400;
    localparam int DRAIN_CYCLES = ALPHABET * (ALPHABET + 3) + 16;
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        prp_pkg::op_t      op;
        logic [POS_W-1:0]  position;
        logic [RES_W-1:0]  residue;
        logic [RANK_W-1:0] rank;
    } profile_item_t;

    typedef struct packed {
        logic              found;
        logic [RES_W-1:0]  residue;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  total;
        logic [PCT_W-1:0]  pct;
    } ranked_entry_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [S_DW-1:0] s_tdata = '0;
    logic            s_tuser = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_DW-1:0] m_tdata;
    logic            m_tuser;

    // local copy of the profile
    bit [CNT_W-1:0] cell_count [POSITIONS][ALPHABET];
    bit [CNT_W-1:0] column_total [POSITIONS];

    profile_item_t pending_items [$];
    ranked_entry_t ranked_due [$];

    profile_item_t cur_item;
    bit            cur_valid = 1'b0;

    bit [POS_W-1:0] hot_pos [HOT_N];
    bit [RES_W-1:0] res_pool [POOL_N];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned n_counts = 0;
    int unsigned n_queries = 0;
    int unsigned n_checked = 0;

    position_residue_profile u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one accepted transfer to the local profile; queries queue their result
    task automatic profile_update(input profile_item_t it);
        int unsigned   cc;
        int unsigned   cd;
        int unsigned   tot;
        int unsigned   place;
        int unsigned   share;
        bit            hit;
        ranked_entry_t r;
        begin
            if (it.op == prp_pkg::OP_COUNT) begin
                n_counts++;
                if (cell_count[it.position][it.residue] != COUNT_MAX)
                    cell_count[it.position][it.residue]++;
                if (column_total[it.position] != COUNT_MAX)
                    column_total[it.position]++;
            end else begin
                n_queries++;
                hit = 1'b0;
                tot = 32'(column_total[it.position]);
                for (int c = 0; c < ALPHABET && !hit; c++) begin
                    cc = 32'(cell_count[it.position][c]);
                    if (cc != 0) begin
                        place = 0;
                        // higher counts rank first, ties go to the lower code
                        for (int d = 0; d < ALPHABET; d++) begin
                            cd = 32'(cell_count[it.position][d]);
                            if (cd > cc || (cd == cc && d < c))
                                place++;
                        end
                        if (place == it.rank) begin
                            hit = 1'b1;
                            share = (cc * 32'(prp_pkg::PCT_SCALE)) / tot;
                            if (share > 32'(prp_pkg::PCT_SCALE))
                                share = 32'(prp_pkg::PCT_SCALE);
                            r.found   = 1'b1;
                            r.residue = RES_W'(c);
                            r.count   = CNT_W'(cc);
                            r.total   = CNT_W'(tot);
                            r.pct     = PCT_W'(share);
                        end
                    end
                end
                if (hit)
                    ranked_due.push_back(r);
            end
        end
    endtask

    task automatic push_item(input prp_pkg::op_t op, input int position, input int residue,
                             input int rank);
        profile_item_t it;
        begin
            it.op       = op;
            it.position = POS_W'(position);
            it.residue  = RES_W'(residue);
            it.rank     = RANK_W'(rank);
            pending_items.push_back(it);
        end
    endtask

    // random traffic centered on a few columns so queries mostly land on seen data
    task automatic queue_random_phase(input int n);
        profile_item_t it;
        begin
            for (int i = 0; i < HOT_N; i++)
                hot_pos[i] = POS_W'($urandom_range(POSITIONS - 1));
            for (int i = 0; i < POOL_N; i++)
                res_pool[i] = RES_W'($urandom_range(ALPHABET - 1));
            for (int i = 0; i < n; i++) begin
                it.op = ($urandom_range(99) < 20) ? prp_pkg::OP_QUERY : prp_pkg::OP_COUNT;
                it.position = ($urandom_range(9) == 0) ? POS_W'($urandom_range(POSITIONS - 1))
                                                       : hot_pos[$urandom_range(HOT_N - 1)];
                it.residue = ($urandom_range(9) == 0) ? RES_W'($urandom_range(ALPHABET - 1))
                                                      : res_pool[$urandom_range(POOL_N - 1)];
                it.rank = ($urandom_range(3) == 0) ? RANK_W'($urandom_range((1 << RANK_W) - 1))
                                                   : RANK_W'($urandom_range(5));
                pending_items.push_back(it);
            end
        end
    endtask

    task automatic wait_sent;
        begin
            while (pending_items.size() != 0 || cur_valid)
                @(posedge aclk);
        end
    endtask

    // input side: present queued items, update the local profile on each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            cur_valid = 1'b0;
        end else begin
            if (cur_valid && s_tready) begin
                profile_update(cur_item);
                cur_valid = 1'b0;
            end
            if (!cur_valid && pending_items.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                cur_item  = pending_items.pop_front();
                cur_valid = 1'b1;
            end
            s_tvalid <= cur_valid;
            s_tdata  <= {{(S_DW - POS_W - RES_W - RANK_W){1'b0}},
                         cur_item.rank, cur_item.residue, cur_item.position};
            s_tuser  <= cur_item.op;
        end
    end

    // result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        ranked_entry_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ranked_due.size() == 0) begin
                    $error("result transfer with no query awaiting it");
                    errors++;
                end else begin
                    want = ranked_due.pop_front();
                    n_checked++;
                    if (m_tuser !== want.found) begin
                        $error("found expected %0d got %0d", want.found, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== want.residue) begin
                        $error("ranked_residue expected %0d got %0d",
                               want.residue, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[23:8] !== want.count) begin
                        $error("residue_count expected %0d got %0d",
                               want.count, m_tdata[23:8]);
                        errors++;
                    end
                    if (m_tdata[39:24] !== want.total) begin
                        $error("column_total expected %0d got %0d",
                               want.total, m_tdata[39:24]);
                        errors++;
                    end
                    if (m_tdata[49:40] !== want.pct) begin
                        $error("percent_tenths expected %0d got %0d",
                               want.pct, m_tdata[49:40]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 14;
        recv_idle_pct = 52;
        push_item(prp_pkg::OP_QUERY, 0, 255, 0);     // empty column, nothing to rank
        push_item(prp_pkg::OP_COUNT, 0, 0, 255);     // rank field ignored on counts
        push_item(prp_pkg::OP_COUNT, 0, 255, 0);
        push_item(prp_pkg::OP_COUNT, 0, 255, 0);
        push_item(prp_pkg::OP_QUERY, 0, 0, 0);
        push_item(prp_pkg::OP_QUERY, 0, 0, 1);
        push_item(prp_pkg::OP_QUERY, 0, 0, 2);       // past the seen residues
        push_item(prp_pkg::OP_QUERY, 0, 0, 255);
        push_item(prp_pkg::OP_COUNT, 1023, 7, 0);
        push_item(prp_pkg::OP_COUNT, 1023, 3, 0);
        push_item(prp_pkg::OP_QUERY, 1023, 255, 0);  // tie goes to the lower code
        push_item(prp_pkg::OP_QUERY, 1023, 0, 1);
        push_item(prp_pkg::OP_COUNT, 1023, 128, 0);
        push_item(prp_pkg::OP_COUNT, 1023, 128, 0);
        push_item(prp_pkg::OP_COUNT, 1023, 128, 0);
        push_item(prp_pkg::OP_QUERY, 1023, 0, 0);
        push_item(prp_pkg::OP_QUERY, 1023, 0, 2);
        push_item(prp_pkg::OP_QUERY, 1023, 0, 3);
        push_item(prp_pkg::OP_QUERY, 1022, 0, 0);
        queue_random_phase(PHASE_ITEMS);
        wait_sent();

        send_idle_pct = 52;
        recv_idle_pct = 14;
        queue_random_phase(PHASE_ITEMS);
        wait_sent();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_sent();

        while (ranked_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ranked_due.size() != 0) begin
            $error("%0d ranked results never arrived", ranked_due.size());
            errors++;
        end

        $display("covered %0d count and %0d query transfers, %0d ranked results compared",
                 n_counts, n_queries, n_checked);
        $display("three backpressure mixes, empty columns, ties and ranks past the seen set");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/prp_pkg.sv
rtl/position_residue_profile.sv
rtl/prp_checker.sv
test/testbench.sv
